// File: design/ltl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ltl_pkg
// Shared types, character codes and helper functions for the lexer block.
// ----------------------------------------------------------------------------
package ltl_pkg;

    // token kinds on the result channel
    typedef enum logic [2:0] {
        KIND_END     = 3'd0,
        KIND_PUNCT   = 3'd1,
        KIND_INT     = 3'd2,
        KIND_CHAR    = 3'd3,
        KIND_FLOAT   = 3'd4,
        KIND_IDENT   = 3'd5,
        KIND_STR_BYTE = 3'd6,
        KIND_STR_END = 3'd7
    } t_kind;

    // error codes carried on tokens
    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_EMPTY     = 3'd1,
        ERR_NEWLINE   = 3'd2,
        ERR_ESCAPE    = 3'd3,
        ERR_NO_CLOSE  = 3'd4,
        ERR_OVERFLOW  = 3'd5,
        ERR_BAD_DIGIT = 3'd6
    } t_err;

    // scanner modes
    typedef enum logic [3:0] {
        MODE_IDLE       = 4'd0,
        MODE_IDENT      = 4'd1,
        MODE_NUM        = 4'd2,
        MODE_FLOAT      = 4'd3,
        MODE_CHAR_OPEN  = 4'd4,
        MODE_CHAR_ESC   = 4'd5,
        MODE_CHAR_CLOSE = 4'd6,
        MODE_STR        = 4'd7,
        MODE_STR_ESC    = 4'd8
    } t_mode;

    // number base
    typedef enum logic [1:0] {
        BASE_DEC = 2'd0,
        BASE_OCT = 2'd1,
        BASE_HEX = 2'd2
    } t_base;

    // token fields other than the value
    typedef struct packed {
        t_kind      kind;
        t_err       err;
        logic [7:0] len;
    } t_tok_meta;

    localparam int TOK_META_BITS = $bits(t_tok_meta);
    localparam int TOKQ_DEPTH    = 4;

    // character codes
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NL      = 8'h0a;
    localparam logic [7:0] CH_VT      = 8'h0b;
    localparam logic [7:0] CH_CR      = 8'h0d;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_SQUOTE  = 8'h27;
    localparam logic [7:0] CH_PLUS    = 8'h2b;
    localparam logic [7:0] CH_MINUS   = 8'h2d;
    localparam logic [7:0] CH_DOT     = 8'h2e;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_E = 8'h45;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] CH_UPPER_Z = 8'h5a;
    localparam logic [7:0] CH_BSLASH  = 8'h5c;
    localparam logic [7:0] CH_UNDER   = 8'h5f;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_B = 8'h62;
    localparam logic [7:0] CH_LOWER_E = 8'h65;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_LOWER_N = 8'h6e;
    localparam logic [7:0] CH_LOWER_R = 8'h72;
    localparam logic [7:0] CH_LOWER_T = 8'h74;
    localparam logic [7:0] CH_LOWER_V = 8'h76;
    localparam logic [7:0] CH_LOWER_X = 8'h78;
    localparam logic [7:0] CH_LOWER_Z = 8'h7a;

    // digit value marking a byte that is no hex digit
    localparam logic [4:0] NO_DIGIT = 5'd16;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) ||
               ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) || (c == CH_UNDER);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_NL) || (c == CH_CR) ||
               (c == CH_TAB) || (c == CH_VT);
    endfunction

    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [7:0] d;
        d = 8'(NO_DIGIT);
        if (is_digit(c)) begin
            d = c - CH_ZERO;
        end else if ((c >= CH_LOWER_A) && (c <= CH_LOWER_F)) begin
            d = c - CH_LOWER_A + 8'd10;
        end else if ((c >= CH_UPPER_A) && (c <= CH_UPPER_F)) begin
            d = c - CH_UPPER_A + 8'd10;
        end
        return d[4:0];
    endfunction

    // escape decode: bit 8 set when the escape is known, low bits the value
    function automatic logic [8:0] esc_val(input logic [7:0] c);
        logic [8:0] r;
        case (c)
            CH_LOWER_R: r = {1'b1, 8'd13};
            CH_LOWER_N: r = {1'b1, 8'd10};
            CH_LOWER_T: r = {1'b1, 8'd9};
            CH_LOWER_V: r = {1'b1, 8'd11};
            CH_LOWER_B: r = {1'b1, 8'd8};
            CH_LOWER_A: r = {1'b1, 8'd7};
            CH_ZERO:    r = {1'b1, 8'd0};
            default:    r = 9'd0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] sat_inc(input logic [7:0] v);
        return (v == 8'hff) ? 8'hff : v + 8'd1;
    endfunction

    function automatic logic [4:0] radix(input t_base b);
        logic [4:0] r;
        case (b)
            BASE_HEX: r = 5'd16;
            BASE_OCT: r = 5'd8;
            default:  r = 5'd10;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// File: design/ltl_scan.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ltl_scan
// Scanner state and the per-byte decision: consumes one byte per step and
// produces up to two tokens plus the next scanner state.
// ----------------------------------------------------------------------------
module ltl_scan
    import ltl_pkg::*;
#(
    parameter int VALUE_BITS = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_step,
    input  wire logic [7:0]            i_byte,
    output logic [1:0]                 o_push,
    output t_tok_meta                  o_meta0,
    output logic [VALUE_BITS-1:0]      o_val0,
    output t_tok_meta                  o_meta1,
    output logic [VALUE_BITS-1:0]      o_val1
);

    localparam int WIDE_BITS = VALUE_BITS + 5;

    // scanner state
    t_mode                 r_mode,  n_mode;
    logic [VALUE_BITS-1:0] r_value, n_value;
    t_base                 r_base,  n_base;
    t_err                  r_pend,  n_pend;
    logic [7:0]            r_cnt,   n_cnt;
    logic [7:0]            r_lit,   n_lit;

    logic [7:0] c;
    logic [7:0] cnt_inc;
    logic [4:0] dig;
    logic [8:0] esc;
    assign c       = i_byte;
    assign cnt_inc = sat_inc(r_cnt);
    assign dig     = hex_val(c);
    assign esc     = esc_val(c);

    // outcome of scanning the byte from idle
    t_mode                 id_mode;
    t_base                 id_base;
    logic [VALUE_BITS-1:0] id_value;
    logic                  id_emit;
    t_tok_meta             id_meta;
    logic [VALUE_BITS-1:0] id_val;

    always_comb begin
        id_mode  = MODE_IDLE;
        id_base  = BASE_DEC;
        id_value = '0;
        id_emit  = 1'b0;
        id_meta  = '{kind: KIND_END, err: ERR_NONE, len: 8'd0};
        id_val   = '0;
        if (c == CH_NUL) begin
            id_emit = 1'b1;
        end else if (is_space(c)) begin
            id_emit = 1'b0;
        end else if (c == CH_SQUOTE) begin
            id_mode = MODE_CHAR_OPEN;
        end else if (c == CH_DQUOTE) begin
            id_mode = MODE_STR;
        end else if (c == CH_DOT) begin
            id_mode = MODE_FLOAT;
        end else if (c == CH_ZERO) begin
            id_mode = MODE_NUM;
            id_base = BASE_OCT;
        end else if (is_digit(c)) begin
            id_mode  = MODE_NUM;
            id_value = VALUE_BITS'(dig);
        end else if (is_alpha(c)) begin
            id_mode = MODE_IDENT;
        end else begin
            id_emit = 1'b1;
            id_meta = '{kind: KIND_PUNCT, err: ERR_NONE, len: 8'd1};
            id_val  = VALUE_BITS'(c);
        end
    end

    // digit accumulate: value * base + digit, with overflow from the top bits
    logic [WIDE_BITS-1:0] v_ext;
    logic [WIDE_BITS-1:0] v_mul;
    logic [WIDE_BITS-1:0] v_sum;
    logic                 v_ovf;
    assign v_ext = WIDE_BITS'(r_value);

    always_comb begin
        case (r_base)
            BASE_HEX: v_mul = v_ext << 4;
            BASE_OCT: v_mul = v_ext << 3;
            default:  v_mul = (v_ext << 3) + (v_ext << 1);
        endcase
    end

    assign v_sum = v_mul + WIDE_BITS'(dig);
    assign v_ovf = |v_sum[WIDE_BITS-1:VALUE_BITS];

    // number token as it stands now
    t_err num_err;
    always_comb begin
        num_err = r_pend;
        if ((r_base == BASE_HEX) && (r_cnt == 8'd2) && (r_pend == ERR_NONE)) begin
            num_err = ERR_BAD_DIGIT;
        end
    end

    // per-byte decision
    logic                  restart;
    logic                  has_fin;
    t_tok_meta             fin_meta;
    logic [VALUE_BITS-1:0] fin_val;

    always_comb begin
        n_mode   = r_mode;
        n_value  = r_value;
        n_base   = r_base;
        n_pend   = r_pend;
        n_cnt    = r_cnt;
        n_lit    = r_lit;
        restart  = 1'b0;
        has_fin  = 1'b0;
        fin_meta = '{kind: KIND_END, err: ERR_NONE, len: 8'd0};
        fin_val  = '0;
        o_push   = 2'd0;
        o_meta0  = '{kind: KIND_END, err: ERR_NONE, len: 8'd0};
        o_val0   = '0;
        o_meta1  = '{kind: KIND_END, err: ERR_NONE, len: 8'd0};
        o_val1   = '0;

        unique case (r_mode)
            MODE_IDENT: begin
                if (is_alpha(c) || is_digit(c)) begin
                    n_cnt = cnt_inc;
                end else begin
                    has_fin  = 1'b1;
                    restart  = 1'b1;
                    fin_meta = '{kind: KIND_IDENT, err: ERR_NONE, len: r_cnt};
                end
            end
            MODE_NUM: begin
                if (r_base == BASE_HEX && dig != NO_DIGIT) begin
                    n_cnt = cnt_inc;
                    if (r_pend == ERR_NONE) begin
                        if (v_ovf) begin
                            n_pend  = ERR_OVERFLOW;
                            n_value = '0;
                        end else begin
                            n_value = v_sum[VALUE_BITS-1:0];
                        end
                    end
                end else if (r_base != BASE_HEX && c == CH_LOWER_X &&
                             r_base == BASE_OCT && r_cnt == 8'd1) begin
                    n_base = BASE_HEX;
                    n_cnt  = 8'd2;
                end else if (r_base != BASE_HEX && is_digit(c)) begin
                    n_cnt = cnt_inc;
                    if (dig < radix(r_base)) begin
                        if (r_pend == ERR_NONE) begin
                            if (v_ovf) begin
                                n_pend  = ERR_OVERFLOW;
                                n_value = '0;
                            end else begin
                                n_value = v_sum[VALUE_BITS-1:0];
                            end
                        end
                    end else if (r_pend == ERR_NONE) begin
                        n_pend = ERR_BAD_DIGIT;
                    end
                end else if (r_base != BASE_HEX && (c == CH_DOT ||
                             c == CH_LOWER_E || c == CH_UPPER_E)) begin
                    n_mode = MODE_FLOAT;
                    n_pend = ERR_NONE;
                    n_cnt  = cnt_inc;
                end else begin
                    has_fin  = 1'b1;
                    restart  = 1'b1;
                    fin_meta = '{kind: KIND_INT, err: num_err, len: r_cnt};
                    fin_val  = (num_err == ERR_NONE) ? r_value : '0;
                end
            end
            MODE_FLOAT: begin
                if (is_digit(c) || c == CH_DOT || c == CH_LOWER_E ||
                    c == CH_UPPER_E || c == CH_PLUS || c == CH_MINUS) begin
                    n_cnt = cnt_inc;
                end else begin
                    has_fin  = 1'b1;
                    restart  = 1'b1;
                    fin_meta = '{kind: KIND_FLOAT, err: ERR_NONE, len: r_cnt};
                end
            end
            MODE_CHAR_OPEN: begin
                if (c == CH_NUL) begin
                    has_fin  = 1'b1;
                    restart  = 1'b1;
                    fin_meta = '{kind: KIND_CHAR, err: ERR_NO_CLOSE, len: r_cnt};
                end else begin
                    n_cnt = cnt_inc;
                    if (c == CH_SQUOTE) begin
                        o_push  = 2'd1;
                        o_meta0 = '{kind: KIND_CHAR, err: ERR_EMPTY, len: cnt_inc};
                        n_mode  = MODE_IDLE;
                    end else if (c == CH_BSLASH) begin
                        n_mode = MODE_CHAR_ESC;
                    end else begin
                        if (c == CH_NL) begin
                            n_pend = ERR_NEWLINE;
                        end
                        n_lit  = c;
                        n_mode = MODE_CHAR_CLOSE;
                    end
                end
            end
            MODE_CHAR_ESC: begin
                if (c == CH_NUL) begin
                    has_fin  = 1'b1;
                    restart  = 1'b1;
                    fin_meta = '{kind: KIND_CHAR, err: ERR_NO_CLOSE, len: r_cnt};
                end else begin
                    n_cnt = cnt_inc;
                    if (!esc[8] && r_pend == ERR_NONE) begin
                        n_pend = ERR_ESCAPE;
                    end
                    n_lit  = esc[7:0];
                    n_mode = MODE_CHAR_CLOSE;
                end
            end
            MODE_CHAR_CLOSE: begin
                if (c == CH_SQUOTE) begin
                    n_cnt   = cnt_inc;
                    o_push  = 2'd1;
                    o_meta0 = '{kind: KIND_CHAR, err: r_pend, len: cnt_inc};
                    o_val0  = VALUE_BITS'(r_lit);
                    n_mode  = MODE_IDLE;
                end else begin
                    has_fin  = 1'b1;
                    restart  = 1'b1;
                    fin_meta = '{kind: KIND_CHAR,
                                 err: (r_pend != ERR_NONE) ? r_pend : ERR_NO_CLOSE,
                                 len: r_cnt};
                    fin_val  = VALUE_BITS'(r_lit);
                end
            end
            MODE_STR: begin
                if (c == CH_NUL) begin
                    has_fin  = 1'b1;
                    restart  = 1'b1;
                    fin_meta = '{kind: KIND_STR_END, err: ERR_NO_CLOSE, len: r_cnt};
                end else begin
                    n_cnt = cnt_inc;
                    if (c == CH_DQUOTE) begin
                        o_push  = 2'd1;
                        o_meta0 = '{kind: KIND_STR_END, err: ERR_NONE, len: cnt_inc};
                        n_mode  = MODE_IDLE;
                    end else if (c == CH_BSLASH) begin
                        n_mode = MODE_STR_ESC;
                    end else begin
                        o_push  = 2'd1;
                        o_meta0 = '{kind: KIND_STR_BYTE,
                                    err: (c == CH_NL) ? ERR_NEWLINE : ERR_NONE,
                                    len: 8'd1};
                        o_val0  = VALUE_BITS'(c);
                    end
                end
            end
            MODE_STR_ESC: begin
                if (c == CH_NUL) begin
                    has_fin  = 1'b1;
                    restart  = 1'b1;
                    fin_meta = '{kind: KIND_STR_END, err: ERR_NO_CLOSE, len: r_cnt};
                end else begin
                    n_cnt  = cnt_inc;
                    n_mode = MODE_STR;
                    o_push = 2'd1;
                    if (c == CH_DQUOTE) begin
                        o_meta0 = '{kind: KIND_STR_BYTE, err: ERR_NONE, len: 8'd2};
                        o_val0  = VALUE_BITS'(c);
                    end else if (esc[8]) begin
                        o_meta0 = '{kind: KIND_STR_BYTE, err: ERR_NONE, len: 8'd2};
                        o_val0  = VALUE_BITS'(esc[7:0]);
                    end else begin
                        o_meta0 = '{kind: KIND_STR_BYTE, err: ERR_ESCAPE, len: 8'd2};
                    end
                end
            end
            default: begin
                restart = 1'b1;
            end
        endcase

        // byte rescanned from idle, after any token it closed
        if (restart) begin
            n_mode  = id_mode;
            n_value = id_value;
            n_base  = id_base;
            n_pend  = ERR_NONE;
            n_cnt   = 8'd1;
            n_lit   = 8'd0;
            if (has_fin) begin
                o_meta0 = fin_meta;
                o_val0  = fin_val;
                o_meta1 = id_meta;
                o_val1  = id_val;
                o_push  = id_emit ? 2'd2 : 2'd1;
            end else begin
                o_meta0 = id_meta;
                o_val0  = id_val;
                o_push  = id_emit ? 2'd1 : 2'd0;
            end
        end
        if (!i_step) begin
            o_push = 2'd0;
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_value <= '0;
            r_base  <= BASE_DEC;
            r_pend  <= ERR_NONE;
            r_cnt   <= 8'd0;
            r_lit   <= 8'd0;
        end else if (i_step) begin
            r_mode  <= n_mode;
            r_value <= n_value;
            r_base  <= n_base;
            r_pend  <= n_pend;
            r_cnt   <= n_cnt;
            r_lit   <= n_lit;
        end
    end

endmodule
`default_nettype wire

// File: design/ltl_tokq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ltl_tokq
// Small token queue: takes up to two tokens per cycle, hands out one.
// ----------------------------------------------------------------------------
module ltl_tokq
    import ltl_pkg::*;
#(
    parameter int DATA_BITS = 78
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic [1:0]           i_push,
    input  wire logic [DATA_BITS-1:0] i_data0,
    input  wire logic [DATA_BITS-1:0] i_data1,
    input  wire logic                 i_pop,
    output logic                      o_valid,
    output logic [DATA_BITS-1:0]      o_data,
    output logic                      o_room2
);

    localparam int AW = $clog2(TOKQ_DEPTH);
    localparam int CW = $clog2(TOKQ_DEPTH + 1);

    logic [DATA_BITS-1:0] r_mem [TOKQ_DEPTH];
    logic [AW-1:0]        r_head, n_head;
    logic [AW-1:0]        r_tail, n_tail;
    logic [CW-1:0]        r_count, n_count;
    logic                 pop;
    logic [AW-1:0]        tail1;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_head];
    assign o_room2 = (r_count <= CW'(TOKQ_DEPTH - 2));
    assign pop     = i_pop && o_valid;
    assign tail1   = r_tail + AW'(1);

    // pointer and fill level update
    always_comb begin
        n_head  = pop ? r_head + AW'(1) : r_head;
        n_tail  = r_tail + AW'(i_push);
        n_count = r_count + CW'(i_push) - CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // token storage
    always_ff @(posedge i_clk) begin
        if (i_push != 2'd0) begin
            r_mem[r_tail] <= i_data0;
        end
        if (i_push == 2'd2) begin
            r_mem[tail1] <= i_data1;
        end
    end

endmodule
`default_nettype wire

// File: design/literal_token_lexer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// literal_token_lexer
// Streaming lexer for a C-like language: one source byte in per item,
// tokens out with kind, value, error code and length.
// ----------------------------------------------------------------------------
//  channel   | signals                                  | carries
//  ----------+------------------------------------------+---------------------
//  byte in   | i_in_valid, o_in_ready, i_char_byte      | one source byte
//  token out | o_out_valid, i_out_ready, o_token_kind,  | one token
//            | o_token_value, o_error_code,             |
//            | o_token_length                           |
//
//  One byte per cycle is taken while the token queue has room for two;
//  the queue drains one token per cycle while i_out_ready is high, so a byte
//  that closes one token and starts another yields two tokens.
//  An accepted byte is held in the input register until the queue has room.
//  Synchronous active-low reset puts the scanner in idle and empties the queue.
//  A stalled output stalls the input once the four-entry queue holds three.
// ----------------------------------------------------------------------------
module literal_token_lexer
    import ltl_pkg::*;
#(
    parameter int VALUE_BITS = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [7:0]            i_char_byte,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [2:0]                 o_token_kind,
    output logic [VALUE_BITS-1:0]      o_token_value,
    output logic [2:0]                 o_error_code,
    output logic [7:0]                 o_token_length
);

    localparam int TOK_BITS = TOK_META_BITS + VALUE_BITS;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       step;
    logic       room2;

    assign step       = r_in_valid && room2;
    assign o_in_ready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_char_byte;
        end
    end

    // scanner
    logic [1:0]            push;
    t_tok_meta             meta0;
    t_tok_meta             meta1;
    logic [VALUE_BITS-1:0] val0;
    logic [VALUE_BITS-1:0] val1;

    ltl_scan #(
        .VALUE_BITS(VALUE_BITS)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .o_push  (push),
        .o_meta0 (meta0),
        .o_val0  (val0),
        .o_meta1 (meta1),
        .o_val1  (val1)
    );

    // token queue
    logic [TOK_BITS-1:0] q_data;
    t_tok_meta           q_meta;

    ltl_tokq #(
        .DATA_BITS(TOK_BITS)
    ) u_tokq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data0 ({meta0, val0}),
        .i_data1 ({meta1, val1}),
        .i_pop   (i_out_ready),
        .o_valid (o_out_valid),
        .o_data  (q_data),
        .o_room2 (room2)
    );

    // result fields
    assign q_meta         = t_tok_meta'(q_data[TOK_BITS-1:VALUE_BITS]);
    assign o_token_kind   = q_meta.kind;
    assign o_error_code   = q_meta.err;
    assign o_token_length = q_meta.len;
    assign o_token_value  = q_data[VALUE_BITS-1:0];

    // checks
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("token output valid right after reset");

    a_stall_holds_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !room2 |=> r_in_valid && $stable(r_in_byte))
        else $error("buffered byte lost while queue full");

    a_end_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_token_kind == KIND_END |->
            o_token_value == '0 && o_token_length == 8'd0 && o_error_code == ERR_NONE)
        else $error("end token carries data");

    a_str_byte_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_token_kind == KIND_STR_BYTE |->
            o_token_length == 8'd1 || o_token_length == 8'd2)
        else $error("string byte length out of range");

    a_int_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_token_kind == KIND_INT && o_error_code != ERR_NONE |->
            o_token_value == '0)
        else $error("integer with error has nonzero value");

endmodule
`default_nettype wire

// File: bench/tb_literal_token_lexer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_literal_token_lexer
// Self-checking bench for the byte-stream lexer. A short table of directed
// bytes comes first, then a random stream of well-formed and broken lexemes.
// Every accepted byte runs through an in-bench scanner model; its tokens, or a
// typed row's own token, are queued, and each output token is compared field
// by field against the oldest queued one. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_literal_token_lexer;
    import ltl_pkg::*;

    localparam int RANDOM_ITEMS = 600;
    localparam int DIR_COUNT    = 25;

    typedef struct packed {
        t_kind       kind;
        logic [63:0] value;
        t_err        err;
        logic [7:0]  len;
    } t_lex_token;

    typedef struct packed {
        logic [7:0] ch;
        logic       typed;
        t_lex_token tok;
    } t_dir_row;

    localparam t_lex_token NO_TOK = '0;

    // directed bytes; typed rows carry the token they must produce
    localparam t_dir_row DIR_ROWS [DIR_COUNT] = '{
        '{CH_NUL,     1'b1, '{KIND_END,      64'd0,  ERR_NONE,      8'd0}},
        '{CH_PLUS,    1'b1, '{KIND_PUNCT,    64'h2b, ERR_NONE,      8'd1}},
        '{8'h0c,      1'b1, '{KIND_PUNCT,    64'h0c, ERR_NONE,      8'd1}},
        '{8'hff,      1'b1, '{KIND_PUNCT,    64'hff, ERR_NONE,      8'd1}},
        '{CH_SQUOTE,  1'b0, NO_TOK},
        '{CH_SQUOTE,  1'b1, '{KIND_CHAR,     64'd0,  ERR_EMPTY,     8'd2}},
        '{CH_ZERO,    1'b0, NO_TOK},
        '{CH_LOWER_X, 1'b0, NO_TOK},
        '{CH_SPACE,   1'b1, '{KIND_INT,      64'd0,  ERR_BAD_DIGIT, 8'd2}},
        '{CH_ZERO,    1'b0, NO_TOK},
        '{CH_SPACE,   1'b1, '{KIND_INT,      64'd0,  ERR_NONE,      8'd1}},
        '{CH_ZERO,    1'b0, NO_TOK},
        '{CH_NINE,    1'b0, NO_TOK},
        '{CH_SPACE,   1'b1, '{KIND_INT,      64'd0,  ERR_BAD_DIGIT, 8'd2}},
        '{CH_SQUOTE,  1'b0, NO_TOK},
        '{CH_NL,      1'b0, NO_TOK},
        '{CH_SQUOTE,  1'b1, '{KIND_CHAR,     64'h0a, ERR_NEWLINE,   8'd3}},
        '{CH_DQUOTE,  1'b0, NO_TOK},
        '{CH_BSLASH,  1'b0, NO_TOK},
        '{8'h71,      1'b1, '{KIND_STR_BYTE, 64'd0,  ERR_ESCAPE,    8'd2}},
        '{CH_DQUOTE,  1'b1, '{KIND_STR_END,  64'd0,  ERR_NONE,      8'd4}},
        '{CH_SQUOTE,  1'b0, NO_TOK},
        '{CH_LOWER_A, 1'b0, NO_TOK},
        '{CH_LOWER_B, 1'b1, '{KIND_CHAR,     64'h61, ERR_NO_CLOSE,  8'd2}},
        '{CH_NUL,     1'b0, NO_TOK}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic [7:0]  char_byte = 8'd0;
    logic        out_ready = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [2:0]  o_token_kind;
    logic [63:0] o_token_value;
    logic [2:0]  o_error_code;
    logic [7:0]  o_token_length;

    // scanner model state
    t_mode       lex_mode = MODE_IDLE;
    logic [63:0] num_acc = '0;
    t_base       num_base = BASE_DEC;
    t_err        held_err = ERR_NONE;
    logic [7:0]  tok_len = '0;
    logic [7:0]  lit_byte = '0;

    t_lex_token  step_tokens [$];
    t_lex_token  due_tokens [$];
    logic [7:0]  lexeme [$];
    int          mismatch_count = 0;
    int          src_count = 0;
    int          rx_stall = 0;
    logic        no_gaps = 1'b0;

    literal_token_lexer u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (o_in_ready),
        .i_char_byte    (char_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (out_ready),
        .o_token_kind   (o_token_kind),
        .o_token_value  (o_token_value),
        .o_error_code   (o_error_code),
        .o_token_length (o_token_length)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // character classes
    function automatic logic is_dec(input logic [7:0] c);
        return c inside {[CH_ZERO:CH_NINE]};
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return c inside {[CH_LOWER_A:CH_LOWER_Z], [CH_UPPER_A:CH_UPPER_Z], CH_UNDER};
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c inside {CH_SPACE, CH_NL, CH_CR, CH_TAB, CH_VT};
    endfunction

    function automatic logic [4:0] digit_of(input logic [7:0] c);
        if (is_dec(c)) return 5'(c - CH_ZERO);
        if (c inside {[CH_LOWER_A:CH_LOWER_F]}) return 5'(c - CH_LOWER_A + 8'd10);
        if (c inside {[CH_UPPER_A:CH_UPPER_F]}) return 5'(c - CH_UPPER_A + 8'd10);
        return 5'd16;
    endfunction

    function automatic logic [7:0] escape_of(input logic [7:0] c, output logic known);
        logic [7:0] v;
        known = 1'b1;
        case (c)
            CH_LOWER_R: v = CH_CR;
            CH_LOWER_N: v = CH_NL;
            CH_LOWER_T: v = CH_TAB;
            CH_LOWER_V: v = CH_VT;
            CH_LOWER_B: v = 8'h08;
            CH_LOWER_A: v = 8'h07;
            CH_ZERO:    v = CH_NUL;
            default: begin
                v = CH_NUL;
                known = 1'b0;
            end
        endcase
        return v;
    endfunction

    function automatic logic [7:0] sat_up(input logic [7:0] v);
        return (v == 8'hff) ? v : v + 8'd1;
    endfunction

    function automatic logic [63:0] base_radix(input t_base b);
        case (b)
            BASE_HEX: return 64'd16;
            BASE_OCT: return 64'd8;
            default:  return 64'd10;
        endcase
    endfunction

    task automatic put_token(input t_kind kind, input logic [63:0] value, input t_err err,
                             input logic [7:0] len);
        t_lex_token t;
        t.kind  = kind;
        t.value = value;
        t.err   = err;
        t.len   = len;
        step_tokens.push_back(t);
    endtask

    // byte seen while idle: opens a token or stands alone
    task automatic start_token(input logic [7:0] c);
        lex_mode = MODE_IDLE;
        tok_len  = 8'd1;
        held_err = ERR_NONE;
        num_acc  = '0;
        num_base = BASE_DEC;
        lit_byte = '0;
        if (c == CH_NUL) begin
            put_token(KIND_END, 64'd0, ERR_NONE, 8'd0);
        end else if (!is_blank(c)) begin
            if (c == CH_SQUOTE) begin
                lex_mode = MODE_CHAR_OPEN;
            end else if (c == CH_DQUOTE) begin
                lex_mode = MODE_STR;
            end else if (c == CH_DOT) begin
                lex_mode = MODE_FLOAT;
            end else if (c == CH_ZERO) begin
                lex_mode = MODE_NUM;
                num_base = BASE_OCT;
            end else if (is_dec(c)) begin
                lex_mode = MODE_NUM;
                num_acc  = 64'(c - CH_ZERO);
            end else if (is_letter(c)) begin
                lex_mode = MODE_IDENT;
            end else begin
                put_token(KIND_PUNCT, 64'(c), ERR_NONE, 8'd1);
            end
        end
    endtask

    // multiply-add with overflow detection; the first error sticks
    task automatic add_digit(input logic [4:0] d);
        logic [63:0] b;
        b = base_radix(num_base);
        tok_len = sat_up(tok_len);
        if (held_err == ERR_NONE) begin
            if (num_acc > (64'hffff_ffff_ffff_ffff - 64'(d)) / b) begin
                held_err = ERR_OVERFLOW;
                num_acc  = '0;
            end else begin
                num_acc = num_acc * b + 64'(d);
            end
        end
    endtask

    // scanner model: tokens caused by one source byte go to step_tokens
    task automatic scan_source_byte(input logic [7:0] c);
        logic [4:0] d;
        logic [7:0] v;
        logic       known;
        t_err       err;
        case (lex_mode)
            MODE_IDENT: begin
                if (is_letter(c) || is_dec(c)) begin
                    tok_len = sat_up(tok_len);
                end else begin
                    put_token(KIND_IDENT, 64'd0, ERR_NONE, tok_len);
                    start_token(c);
                end
            end
            MODE_NUM: begin
                d = digit_of(c);
                if (num_base == BASE_HEX && d < 5'd16) begin
                    add_digit(d);
                end else if (num_base != BASE_HEX && c == CH_LOWER_X &&
                             num_base == BASE_OCT && tok_len == 8'd1) begin
                    num_base = BASE_HEX;
                    tok_len  = 8'd2;
                end else if (num_base != BASE_HEX && is_dec(c)) begin
                    if (64'(d) < base_radix(num_base)) begin
                        add_digit(d);
                    end else begin
                        if (held_err == ERR_NONE) held_err = ERR_BAD_DIGIT;
                        tok_len = sat_up(tok_len);
                    end
                end else if (num_base != BASE_HEX &&
                             c inside {CH_DOT, CH_LOWER_E, CH_UPPER_E}) begin
                    lex_mode = MODE_FLOAT;
                    held_err = ERR_NONE;
                    tok_len  = sat_up(tok_len);
                end else begin
                    // number ends; a bare 0x has no digits
                    err = held_err;
                    if (num_base == BASE_HEX && tok_len == 8'd2 && err == ERR_NONE)
                        err = ERR_BAD_DIGIT;
                    put_token(KIND_INT, (err == ERR_NONE) ? num_acc : 64'd0, err, tok_len);
                    start_token(c);
                end
            end
            MODE_FLOAT: begin
                if (is_dec(c) || c inside {CH_DOT, CH_LOWER_E, CH_UPPER_E, CH_PLUS, CH_MINUS})
                begin
                    tok_len = sat_up(tok_len);
                end else begin
                    put_token(KIND_FLOAT, 64'd0, ERR_NONE, tok_len);
                    start_token(c);
                end
            end
            MODE_CHAR_OPEN, MODE_CHAR_ESC: begin
                if (c == CH_NUL) begin
                    put_token(KIND_CHAR, 64'd0, ERR_NO_CLOSE, tok_len);
                    start_token(c);
                end else begin
                    tok_len = sat_up(tok_len);
                    if (lex_mode == MODE_CHAR_ESC) begin
                        v = escape_of(c, known);
                        if (!known && held_err == ERR_NONE) held_err = ERR_ESCAPE;
                        lit_byte = v;
                        lex_mode = MODE_CHAR_CLOSE;
                    end else if (c == CH_SQUOTE) begin
                        put_token(KIND_CHAR, 64'd0, ERR_EMPTY, tok_len);
                        lex_mode = MODE_IDLE;
                    end else if (c == CH_BSLASH) begin
                        lex_mode = MODE_CHAR_ESC;
                    end else begin
                        if (c == CH_NL) held_err = ERR_NEWLINE;
                        lit_byte = c;
                        lex_mode = MODE_CHAR_CLOSE;
                    end
                end
            end
            MODE_CHAR_CLOSE: begin
                if (c == CH_SQUOTE) begin
                    tok_len = sat_up(tok_len);
                    put_token(KIND_CHAR, 64'(lit_byte), held_err, tok_len);
                    lex_mode = MODE_IDLE;
                end else begin
                    put_token(KIND_CHAR, 64'(lit_byte),
                              (held_err != ERR_NONE) ? held_err : ERR_NO_CLOSE, tok_len);
                    start_token(c);
                end
            end
            MODE_STR, MODE_STR_ESC: begin
                if (c == CH_NUL) begin
                    put_token(KIND_STR_END, 64'd0, ERR_NO_CLOSE, tok_len);
                    start_token(c);
                end else begin
                    tok_len = sat_up(tok_len);
                    if (lex_mode == MODE_STR_ESC) begin
                        lex_mode = MODE_STR;
                        v = escape_of(c, known);
                        if (c == CH_DQUOTE)
                            put_token(KIND_STR_BYTE, 64'(c), ERR_NONE, 8'd2);
                        else if (known)
                            put_token(KIND_STR_BYTE, 64'(v), ERR_NONE, 8'd2);
                        else
                            put_token(KIND_STR_BYTE, 64'd0, ERR_ESCAPE, 8'd2);
                    end else if (c == CH_DQUOTE) begin
                        put_token(KIND_STR_END, 64'd0, ERR_NONE, tok_len);
                        lex_mode = MODE_IDLE;
                    end else if (c == CH_BSLASH) begin
                        lex_mode = MODE_STR_ESC;
                    end else begin
                        put_token(KIND_STR_BYTE, 64'(c),
                                  (c == CH_NL) ? ERR_NEWLINE : ERR_NONE, 8'd1);
                    end
                end
            end
            default: start_token(c);
        endcase
    endtask

    // idle lengths: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(6, 24);
    endfunction

    // offer one byte, wait for the handshake, then queue its tokens
    task automatic send_byte(input logic [7:0] c, input logic typed, input t_lex_token tok);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        char_byte <= c;
        do @(posedge clk); while (!o_in_ready);
        scan_source_byte(c);
        if (typed) begin
            due_tokens.push_back(tok);
        end else begin
            foreach (step_tokens[i]) due_tokens.push_back(step_tokens[i]);
        end
        step_tokens.delete();
        if (!is_blank(c)) src_count++;
    endtask

    task automatic hold_until_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (due_tokens.size() != 0);
    endtask

    // random byte pickers
    function automatic logic [7:0] pick_letter();
        int r;
        r = $urandom_range(0, 52);
        if (r < 26) return CH_LOWER_A + 8'(r);
        if (r < 52) return CH_UPPER_A + 8'(r - 26);
        return CH_UNDER;
    endfunction

    function automatic logic [7:0] pick_dec();
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] pick_hex();
        int r;
        r = $urandom_range(0, 21);
        if (r < 10) return CH_ZERO + 8'(r);
        if (r < 16) return CH_LOWER_A + 8'(r - 10);
        return CH_UPPER_A + 8'(r - 16);
    endfunction

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 4))
            0:       return CH_SPACE;
            1:       return CH_NL;
            2:       return CH_CR;
            3:       return CH_TAB;
            default: return CH_VT;
        endcase
    endfunction

    function automatic logic [7:0] pick_punct();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255));
        while (is_blank(c) || is_letter(c) || is_dec(c) ||
               c inside {CH_SQUOTE, CH_DQUOTE, CH_DOT});
        return c;
    endfunction

    function automatic logic [7:0] pick_escape();
        case ($urandom_range(0, 9))
            0:       return CH_LOWER_R;
            1:       return CH_LOWER_N;
            2:       return CH_LOWER_T;
            3:       return CH_LOWER_V;
            4:       return CH_LOWER_B;
            5:       return CH_LOWER_A;
            6:       return CH_ZERO;
            7:       return CH_DQUOTE;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // numbers at and just past the 64-bit limit
    function automatic string limit_number(input int k);
        case (k)
            0:       return "18446744073709551615";
            1:       return "18446744073709551616";
            2:       return "0xffffffffffffffff";
            3:       return "0xFfffffffffffffff7";
            4:       return "01777777777777777777777";
            5:       return "02000000000000000000000";
            6:       return "020000000000000000000009";
            default: return "0977777777777777777777777";
        endcase
    endfunction

    // one random lexeme into the lexeme queue
    task automatic build_lexeme(input int sel);
        string s;
        lexeme.delete();
        if (sel < 12) begin
            // identifier
            lexeme.push_back(pick_letter());
            repeat ($urandom_range(0, 10))
                lexeme.push_back(($urandom_range(0, 3) == 0) ? pick_dec() : pick_letter());
        end else if (sel < 22) begin
            // decimal
            lexeme.push_back(CH_ZERO + 8'($urandom_range(1, 9)));
            repeat ($urandom_range(0, 19)) lexeme.push_back(pick_dec());
        end else if (sel < 28) begin
            // octal, now and then with 8 or 9
            lexeme.push_back(CH_ZERO);
            repeat ($urandom_range(0, 23))
                lexeme.push_back(CH_ZERO +
                    8'($urandom_range(0, ($urandom_range(0, 7) == 0) ? 9 : 7)));
        end else if (sel < 36) begin
            // hex
            lexeme.push_back(CH_ZERO);
            lexeme.push_back(CH_LOWER_X);
            repeat ($urandom_range(0, 18)) lexeme.push_back(pick_hex());
        end else if (sel < 44) begin
            // float, from a dot or from digits
            if ($urandom_range(0, 2) == 0) begin
                lexeme.push_back(CH_DOT);
            end else begin
                repeat ($urandom_range(1, 3)) lexeme.push_back(pick_dec());
                case ($urandom_range(0, 2))
                    0:       lexeme.push_back(CH_DOT);
                    1:       lexeme.push_back(CH_LOWER_E);
                    default: lexeme.push_back(CH_UPPER_E);
                endcase
            end
            repeat ($urandom_range(0, 6)) begin
                case ($urandom_range(0, 5))
                    0, 1:    lexeme.push_back(pick_dec());
                    2:       lexeme.push_back(CH_DOT);
                    3:       lexeme.push_back(CH_LOWER_E);
                    4:       lexeme.push_back(CH_UPPER_E);
                    default: lexeme.push_back(($urandom_range(0, 1) == 0) ? CH_PLUS : CH_MINUS);
                endcase
            end
        end else if (sel < 56) begin
            // char literal, sometimes broken
            lexeme.push_back(CH_SQUOTE);
            case ($urandom_range(0, 5))
                0, 1: lexeme.push_back(8'($urandom_range(1, 255)));
                2: begin
                    lexeme.push_back(CH_BSLASH);
                    lexeme.push_back(pick_escape());
                end
                3:       lexeme.push_back(CH_NL);
                4:       lexeme.push_back(CH_NUL);
                default: ; // empty literal
            endcase
            case ($urandom_range(0, 9))
                8:       lexeme.push_back(CH_NUL);
                9:       ; // close quote missing
                default: lexeme.push_back(CH_SQUOTE);
            endcase
        end else if (sel < 68) begin
            // string with plain bytes, escapes and newlines
            lexeme.push_back(CH_DQUOTE);
            repeat ($urandom_range(0, 8)) begin
                case ($urandom_range(0, 5))
                    0, 1, 2: lexeme.push_back(8'($urandom_range(1, 255)));
                    3: begin
                        lexeme.push_back(CH_BSLASH);
                        lexeme.push_back(pick_escape());
                    end
                    4:       lexeme.push_back(CH_NL);
                    default: lexeme.push_back(pick_letter());
                endcase
            end
            lexeme.push_back(($urandom_range(0, 9) < 9) ? CH_DQUOTE : CH_NUL);
        end else if (sel < 80) begin
            repeat ($urandom_range(1, 3)) lexeme.push_back(pick_punct());
        end else if (sel < 85) begin
            lexeme.push_back(CH_NUL);
        end else if (sel < 90) begin
            s = limit_number($urandom_range(0, 7));
            for (int i = 0; i < s.len(); i++) lexeme.push_back(s[i]);
        end else if (sel < 100) begin
            // noise
            repeat ($urandom_range(1, 4)) lexeme.push_back(8'($urandom_range(0, 255)));
        end else if (sel == 100) begin
            // identifier past the length saturation
            repeat (300) lexeme.push_back(pick_letter());
        end else begin
            // string past the length saturation
            lexeme.push_back(CH_DQUOTE);
            repeat (270) lexeme.push_back(pick_letter());
            lexeme.push_back(CH_DQUOTE);
        end
    endtask

    // result side: random stalls
    always @(posedge clk) begin
        if (rst_n) begin
            if (rx_stall > 0) begin
                rx_stall  <= rx_stall - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                rx_stall  <= pick_gap();
            end
        end
    end

    task automatic check_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            mismatch_count++;
        end
    endtask

    // compare each accepted token with the oldest expected one
    always @(posedge clk) begin : token_check
        t_lex_token want;
        if (rst_n && o_out_valid && out_ready) begin
            if (due_tokens.size() == 0) begin
                $error("unexpected token: kind %0d value 0x%0h", o_token_kind, o_token_value);
                mismatch_count++;
            end else begin
                want = due_tokens.pop_front();
                check_field("token_kind", 64'(want.kind), 64'(o_token_kind));
                check_field("token_value", want.value, o_token_value);
                check_field("error_code", 64'(want.err), 64'(o_error_code));
                check_field("token_length", 64'(want.len), 64'(o_token_length));
            end
        end
    end

    // stimulus
    initial begin
        int sel;
        int lex_idx;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int i = 0; i < DIR_COUNT; i++)
            send_byte(DIR_ROWS[i].ch, DIR_ROWS[i].typed, DIR_ROWS[i].tok);
        hold_until_drained();

        // random lexemes with optional blanks between them
        lex_idx = 0;
        while (src_count < RANDOM_ITEMS) begin
            if ($urandom_range(0, 39) == 0) no_gaps <= !no_gaps;
            if (lex_idx % 80 == 79) hold_until_drained();
            if (lex_idx == 20)
                sel = 100;
            else if (lex_idx == 45)
                sel = 101;
            else
                sel = $urandom_range(0, 99);
            build_lexeme(sel);
            foreach (lexeme[i]) send_byte(lexeme[i], 1'b0, NO_TOK);
            if ($urandom_range(0, 9) < 7) send_byte(pick_blank(), 1'b0, NO_TOK);
            lex_idx++;
        end
        send_byte(CH_NUL, 1'b0, NO_TOK);
        in_valid <= 1'b0;

        // drain and settle
        while (due_tokens.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // watchdog
    initial begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
